// ===== rtl/core/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  // result status codes
  localparam logic [2:0] STS_INSERTED = 3'd0;
  localparam logic [2:0] STS_REMOVED  = 3'd1;
  localparam logic [2:0] STS_EMPTY    = 3'd2;
  localparam logic [2:0] STS_FULL     = 3'd3;
  localparam logic [2:0] STS_LISTED   = 3'd4;

  typedef struct packed {
    logic [1:0]                     cmd;
    logic signed [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0]        payload;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]                     status;
    logic signed [KEY_BITS-1:0]     key_res;
    logic [PAYLOAD_BITS-1:0]        payload_res;
    logic                           last;
  } out_beat_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0]        payload;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_op_t op;
    logic     occ;        // cell holds a live entry
    logic     tail;       // last live cell
    logic     left_stay;  // left neighbor keeps its entry on insert
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
`default_nettype none

module spq_cell (
  input  wire                clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_ent,
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  input  spq_pkg::entry_t    head_ent,
  output spq_pkg::entry_t    ent,
  output logic               stay
);

  spq_pkg::entry_t ent_r;

  // keep own entry on insert when it sorts at or before the new key
  assign stay = ctl.occ && (ent_r.key <= new_ent.key);
  assign ent  = ent_r;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      spq_pkg::OP_INSERT: begin
        if (!stay) begin
          ent_r <= ctl.left_stay ? new_ent : left_ent;
        end
      end
      spq_pkg::OP_ROTATE: begin
        ent_r <= ctl.tail ? head_ent : right_ent;
      end
      default: begin
        ent_r <= ent_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// Results: enqueue/dequeue give their single beat in the cycle after acceptance;
//   a list of N entries first enters S_LIST, which then registers each beat.
// Throughput: one enqueue/dequeue per cycle while the output drains; a list
//   holds the input until all N entries are given, one chain rotation per beat.
// Reset: rst_n synchronous, active low; clears the fill count, output valid and
//   sequencer state. Cell contents are not reset (masked by the fill count).
`default_nettype none

module sorted_priority_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  spq_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output spq_pkg::out_beat_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t                      state_r;
  logic [spq_pkg::CNT_W-1:0]   count_r;
  logic [spq_pkg::CNT_W-1:0]   list_left_r;
  logic                        out_valid_r;
  spq_pkg::out_beat_t          out_data_r;

  logic                        out_free;
  logic                        acc;
  logic                        full;
  logic                        empty;
  spq_pkg::cell_op_t           op;
  spq_pkg::entry_t             new_ent;

  // Cell chain wiring: cell 0 is the queue head (smallest key).
  spq_pkg::entry_t             ent  [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]   stay;
  logic [spq_pkg::DEPTH:0]     occ;

  // Output register frees up when empty or when its beat is taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Hold off input while a list walk is running or the output beat is stuck.
  assign in_stall = (state_r == S_LIST) || !out_free;
  assign acc      = in_valid && !in_stall;

  assign full  = (count_r == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty = (count_r == '0);

  assign new_ent.key     = in_data.key;
  assign new_ent.payload = in_data.payload;

  // Chain op for this cycle. Dequeue and each list beat both rotate the live
  // entries left by one, with the head wrapping into the tail cell: after a
  // dequeue the wrapped copy sits past the new count, and after N list beats
  // the order is back where it started.
  always_comb begin
    op = spq_pkg::OP_HOLD;
    if (acc && (in_data.cmd == spq_pkg::CMD_ENQ) && !full) begin
      op = spq_pkg::OP_INSERT;
    end else if (acc && (in_data.cmd == spq_pkg::CMD_DEQ) && !empty) begin
      op = spq_pkg::OP_ROTATE;
    end else if ((state_r == S_LIST) && out_free) begin
      op = spq_pkg::OP_ROTATE;
    end
  end

  assign occ[spq_pkg::DEPTH] = 1'b0;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    left_ent;
    spq_pkg::entry_t    right_ent;

    assign occ[i] = (spq_pkg::CNT_W'(i) < count_r);

    assign ctl.op        = op;
    assign ctl.occ       = occ[i];
    assign ctl.tail      = occ[i] && !occ[i+1];
    // the head cell's "left" always lets the new entry in
    if (i == 0) begin : g_head
      assign ctl.left_stay = 1'b1;
      assign left_ent      = new_ent;
    end else begin : g_body
      assign ctl.left_stay = stay[i-1];
      assign left_ent      = ent[i-1];
    end
    if (i == spq_pkg::DEPTH - 1) begin : g_end
      assign right_ent = ent[0];
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .head_ent  (ent[0]),
      .ent       (ent[i]),
      .stay      (stay[i])
    );
  end

  // Sequencer: state, fill count and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            out_data_r.key_res     <= '0;
            out_data_r.payload_res <= '0;
            out_data_r.last        <= 1'b1;
            unique case (in_data.cmd)
              spq_pkg::CMD_ENQ: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_data_r.status <= spq_pkg::STS_FULL;
                end else begin
                  out_data_r.status <= spq_pkg::STS_INSERTED;
                  count_r           <= count_r + spq_pkg::CNT_W'(1);
                end
              end
              spq_pkg::CMD_DEQ: begin
                out_valid_r <= 1'b1;
                if (empty) begin
                  out_data_r.status <= spq_pkg::STS_EMPTY;
                end else begin
                  out_data_r.status      <= spq_pkg::STS_REMOVED;
                  out_data_r.key_res     <= ent[0].key;
                  out_data_r.payload_res <= ent[0].payload;
                  count_r                <= count_r - spq_pkg::CNT_W'(1);
                end
              end
              spq_pkg::CMD_LIST: begin
                if (empty) begin
                  out_valid_r       <= 1'b1;
                  out_data_r.status <= spq_pkg::STS_EMPTY;
                end else begin
                  state_r     <= S_LIST;
                  list_left_r <= count_r;
                end
              end
              default: begin
                // unused command: no beat, no state change
              end
            endcase
          end
        end
        S_LIST: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.status      <= spq_pkg::STS_LISTED;
            out_data_r.key_res     <= ent[0].key;
            out_data_r.payload_res <= ent[0].payload;
            out_data_r.last        <= (list_left_r == spq_pkg::CNT_W'(1));
            list_left_r            <= list_left_r - spq_pkg::CNT_W'(1);
            if (list_left_r == spq_pkg::CNT_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
`default_nettype none

module spq_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input spq_pkg::in_beat_t  in_data,
  input wire                out_valid,
  input wire                out_stall,
  input spq_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled out beat changed");

  // reset empties the output
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // only removed/listed beats carry an entry
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == spq_pkg::STS_INSERTED ||
                  out_data.status == spq_pkg::STS_EMPTY ||
                  out_data.status == spq_pkg::STS_FULL)
    |-> out_data.key_res == '0 && out_data.payload_res == '0)
    else $error("status beat with nonzero entry fields");

  // every non-list result is the only beat of its command
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != spq_pkg::STS_LISTED |-> out_data.last)
    else $error("single-beat result without last");

  // enqueue and dequeue answer on the next cycle
  a_cmd_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.cmd == spq_pkg::CMD_ENQ || in_data.cmd == spq_pkg::CMD_DEQ)
    |=> out_valid)
    else $error("enqueue/dequeue without a result beat");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
